// File: design/twalk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twalk_pkg;

    // Coordinate width; every other width follows from it
    localparam int COORD_BITS = 12;
    localparam int XW         = COORD_BITS + 1;   // signed border x and DDA terms
    localparam int DEVW       = COORD_BITS + 3;   // deviation, in units of 2*dy
    localparam int PRODW      = 2 * XW;           // area product
    localparam int CNT_W      = $clog2(COORD_BITS);

    // Opcodes of the input item
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch sorted vertices, drop any walk
        logic mul_a;       // first area product
        logic mul_b;       // second area product
        logic setup;       // orientation, flat test, start positions
        logic div_start;   // launch the edge division
        logic div_short;   // division concerns the short side
        logic div_write;   // store quotient, remainder, deviation
        logic emit;        // load the output register and advance a row
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic active;
        logic flat;
        logic last;
        logic mid;
        logic div_done;
    } t_dp_status;

    // One DDA step result
    typedef struct packed {
        logic [XW-1:0]   x;
        logic [DEVW-1:0] dev;
    } t_edge_next;

    // Signed difference of two coordinates
    function automatic logic signed [XW-1:0] coord_diff(t_coord a, t_coord b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // Advance one edge by one row
    function automatic t_edge_next edge_step(logic signed [XW-1:0] x,
                                             logic signed [XW-1:0] q,
                                             logic signed [XW-1:0] r,
                                             logic signed [DEVW-1:0] dev,
                                             t_coord dy);
        logic signed [DEVW-1:0] d;
        logic signed [XW-1:0]   nx;
        t_coord                 ar;
        t_edge_next             res;
        ar = r[XW-1] ? COORD_BITS'(-r) : COORD_BITS'(r);
        d  = dev;
        nx = x;
        if (!dev[DEVW-1]) begin
            d  = d - $signed({2'b00, dy, 1'b0});
            nx = r[XW-1] ? nx - XW'(1) : nx + XW'(1);
        end
        nx = nx + q;
        d  = d + $signed({2'b00, ar, 1'b0});
        res.x   = nx;
        res.dev = d;
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/twalk_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module twalk_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire twalk_pkg::t_coord  i_dividend,
    input  wire twalk_pkg::t_coord  i_divisor,
    output logic                    o_done,
    output twalk_pkg::t_coord       o_quo,
    output twalk_pkg::t_coord       o_rem
);

    logic                              r_busy;
    logic                              r_done;
    logic [twalk_pkg::CNT_W-1:0]       r_cnt;
    twalk_pkg::t_coord                 r_quo;
    twalk_pkg::t_coord                 r_rem;
    twalk_pkg::t_coord                 r_dvs;

    logic [twalk_pkg::COORD_BITS:0]    trial;
    logic [twalk_pkg::COORD_BITS:0]    trial_sub;
    logic                              fits;
    twalk_pkg::t_coord                 n_rem;

    // Shift in one dividend bit and try the subtraction
    always_comb begin
        trial     = {r_rem, r_quo[twalk_pkg::COORD_BITS-1]};
        trial_sub = trial - {1'b0, r_dvs};
        fits      = (trial >= {1'b0, r_dvs});
        n_rem     = fits ? trial_sub[twalk_pkg::COORD_BITS-1:0]
                         : trial[twalk_pkg::COORD_BITS-1:0];
    end

    // Hold the iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == twalk_pkg::CNT_W'(twalk_pkg::COORD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Advance quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[twalk_pkg::COORD_BITS-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: design/twalk_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Vertex store, area products, edge DDA terms and output register
module twalk_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire twalk_pkg::t_dp_cmd     i_cmd,
    output twalk_pkg::t_dp_status       o_status,
    input  wire twalk_pkg::t_coord      i_first_x,
    input  wire twalk_pkg::t_coord      i_first_y,
    input  wire twalk_pkg::t_coord      i_second_x,
    input  wire twalk_pkg::t_coord      i_second_y,
    input  wire twalk_pkg::t_coord      i_third_x,
    input  wire twalk_pkg::t_coord      i_third_y,
    output twalk_pkg::t_coord           o_row_y,
    output twalk_pkg::t_coord           o_left_x,
    output twalk_pkg::t_coord           o_right_x,
    output logic                        o_last_row
);

    localparam int C = twalk_pkg::COORD_BITS;

    // Triangle state
    twalk_pkg::t_coord                      r_vx [3];
    twalk_pkg::t_coord                      r_vy [3];
    twalk_pkg::t_coord                      r_row;
    logic signed [twalk_pkg::XW-1:0]        r_long_x;
    logic signed [twalk_pkg::XW-1:0]        r_short_x;
    logic signed [twalk_pkg::XW-1:0]        r_q   [2];
    logic signed [twalk_pkg::XW-1:0]        r_r   [2];
    logic signed [twalk_pkg::DEVW-1:0]      r_dev [2];
    logic signed [twalk_pkg::PRODW-1:0]     r_prod_a;
    logic signed [twalk_pkg::PRODW-1:0]     r_prod_b;
    logic                                   r_active;
    logic                                   r_lower;
    logic                                   r_neg;

    // Output register
    twalk_pkg::t_coord                      r_out_row;
    twalk_pkg::t_coord                      r_out_left;
    twalk_pkg::t_coord                      r_out_right;
    logic                                   r_out_last;

    // Sorting
    twalk_pkg::t_coord                      sx [3];
    twalk_pkg::t_coord                      sy [3];

    // Multiplier
    logic signed [twalk_pkg::XW-1:0]        mul_l;
    logic signed [twalk_pkg::XW-1:0]        mul_r;
    logic signed [twalk_pkg::PRODW-1:0]     mul_p;

    // Edge under division
    twalk_pkg::t_coord                      xa, ya, xb, yb;
    logic signed [twalk_pkg::XW-1:0]        e_dx;
    logic signed [twalk_pkg::XW-1:0]        e_dx_abs;
    twalk_pkg::t_coord                      e_dy;
    logic                                   e_neg;
    logic                                   div_done;
    twalk_pkg::t_coord                      div_quo;
    twalk_pkg::t_coord                      div_rem;
    logic signed [twalk_pkg::XW-1:0]        wb_q;
    logic signed [twalk_pkg::XW-1:0]        wb_r;
    logic signed [twalk_pkg::DEVW-1:0]      wb_dev;

    // Row step
    twalk_pkg::t_coord                      dy_long;
    twalk_pkg::t_coord                      dy_short;
    twalk_pkg::t_edge_next                  step_long;
    twalk_pkg::t_edge_next                  step_short;
    logic                                   flat;
    logic                                   last;
    logic                                   mid;
    logic                                   upper_flat;

    // Sort the incoming vertices by y, swapping only on strictly greater y
    always_comb begin
        twalk_pkg::t_coord tx;
        twalk_pkg::t_coord ty;
        tx = '0;
        ty = '0;
        sx[0] = i_first_x;  sy[0] = i_first_y;
        sx[1] = i_second_x; sy[1] = i_second_y;
        sx[2] = i_third_x;  sy[2] = i_third_y;
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx;    sy[1] = ty;
        end
        if (sy[1] > sy[2]) begin
            tx = sx[1]; ty = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx;    sy[2] = ty;
        end
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx;    sy[1] = ty;
        end
    end

    // Share one multiplier between the two area products
    always_comb begin
        if (i_cmd.mul_b) begin
            mul_l = twalk_pkg::coord_diff(r_vx[2], r_vx[0]);
            mul_r = twalk_pkg::coord_diff(r_vy[1], r_vy[0]);
        end else begin
            mul_l = twalk_pkg::coord_diff(r_vx[1], r_vx[0]);
            mul_r = twalk_pkg::coord_diff(r_vy[2], r_vy[0]);
        end
        mul_p = mul_l * mul_r;
    end

    // Pick the edge for the divider: long edge, upper or lower short edge
    always_comb begin
        if (!i_cmd.div_short) begin
            xa = r_vx[0]; ya = r_vy[0]; xb = r_vx[2]; yb = r_vy[2];
        end else if (r_lower) begin
            xa = r_vx[1]; ya = r_vy[1]; xb = r_vx[2]; yb = r_vy[2];
        end else begin
            xa = r_vx[0]; ya = r_vy[0]; xb = r_vx[1]; yb = r_vy[1];
        end
        e_dx     = twalk_pkg::coord_diff(xb, xa);
        e_dy     = yb - ya;
        e_neg    = e_dx[twalk_pkg::XW-1];
        e_dx_abs = e_neg ? -e_dx : e_dx;
    end

    twalk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (e_dx_abs[C-1:0]),
        .i_divisor  (e_dy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Truncated signed quotient and remainder, deviation start 2|r| - dy
    always_comb begin
        wb_q   = e_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        wb_r   = e_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
        wb_dev = $signed({2'b00, div_rem, 1'b0}) - $signed({3'b000, e_dy});
    end

    // Row step terms and walk conditions
    always_comb begin
        dy_long    = r_vy[2] - r_vy[0];
        dy_short   = r_lower ? (r_vy[2] - r_vy[1]) : (r_vy[1] - r_vy[0]);
        step_long  = twalk_pkg::edge_step(r_long_x, r_q[0], r_r[0], r_dev[0], dy_long);
        step_short = twalk_pkg::edge_step(r_short_x, r_q[1], r_r[1], r_dev[1], dy_short);
        flat       = (r_vy[0] == r_vy[2]);
        upper_flat = (r_vy[1] == r_vy[0]);
        last       = (r_row == r_vy[2]);
        mid        = !r_lower && (({1'b0, r_row} + 1'b1) == {1'b0, r_vy[1]})
                     && (r_vy[1] < r_vy[2]);
    end

    // Hold the mode flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_lower  <= 1'b0;
            r_neg    <= 1'b0;
        end else if (i_cmd.load) begin
            r_active <= 1'b0;
        end else if (i_cmd.setup) begin
            r_neg    <= (r_prod_a < r_prod_b);
            r_active <= !flat;
            r_lower  <= !flat && upper_flat;
        end else if (i_cmd.emit) begin
            if (last) begin
                r_active <= 1'b0;
            end else if (mid) begin
                r_lower <= 1'b1;
            end
        end
    end

    // Update vertices, products, border positions and DDA terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx <= sx;
            r_vy <= sy;
        end
        if (i_cmd.mul_a) begin
            r_prod_a <= mul_p;
        end
        if (i_cmd.mul_b) begin
            r_prod_b <= mul_p;
        end
        if (i_cmd.setup) begin
            r_row     <= r_vy[0];
            r_long_x  <= $signed({1'b0, r_vx[0]});
            r_short_x <= upper_flat ? $signed({1'b0, r_vx[1]}) : $signed({1'b0, r_vx[0]});
        end
        if (i_cmd.div_write) begin
            if (i_cmd.div_short) begin
                r_q[1]   <= wb_q;
                r_r[1]   <= wb_r;
                r_dev[1] <= wb_dev;
            end else begin
                r_q[0]   <= wb_q;
                r_r[0]   <= wb_r;
                r_dev[0] <= wb_dev;
            end
        end
        if (i_cmd.emit && !last) begin
            r_row    <= r_row + 1'b1;
            r_long_x <= $signed(step_long.x);
            r_dev[0] <= $signed(step_long.dev);
            if (mid) begin
                r_short_x <= $signed({1'b0, r_vx[1]});
            end else begin
                r_short_x <= $signed(step_short.x);
                r_dev[1]  <= $signed(step_short.dev);
            end
        end
    end

    // Load the output register on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row   <= r_row;
            r_out_left  <= r_neg ? r_short_x[C-1:0] : r_long_x[C-1:0];
            r_out_right <= r_neg ? r_long_x[C-1:0]  : r_short_x[C-1:0];
            r_out_last  <= last;
        end
    end

    always_comb begin
        o_status.active   = r_active;
        o_status.flat     = flat;
        o_status.last     = last;
        o_status.mid      = mid;
        o_status.div_done = div_done;
    end

    assign o_row_y    = r_out_row;
    assign o_left_x   = r_out_left;
    assign o_right_x  = r_out_right;
    assign o_last_row = r_out_last;

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_row >= r_vy[0]) && (r_row <= r_vy[2]))
        else $error("walk row outside the triangle");

endmodule

`default_nettype wire

// File: design/twalk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for triangle load and row emission
module twalk_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_opcode,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    input  wire twalk_pkg::t_dp_status   i_status,
    output twalk_pkg::t_dp_cmd           o_cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_MUL_A      = 4'd1;
    localparam logic [3:0] S_MUL_B      = 4'd2;
    localparam logic [3:0] S_SETUP      = 4'd3;
    localparam logic [3:0] S_LONG_GO    = 4'd4;
    localparam logic [3:0] S_LONG_WAIT  = 4'd5;
    localparam logic [3:0] S_SHORT_GO   = 4'd6;
    localparam logic [3:0] S_SHORT_WAIT = 4'd7;
    localparam logic [3:0] S_EMIT       = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_xfer;
    logic       out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequence the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_opcode == twalk_pkg::OPC_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_MUL_A;
                    end else if (i_status.active) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_status.flat ? S_IDLE : S_LONG_GO;
            end
            S_LONG_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_LONG_WAIT;
            end
            S_LONG_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_write = 1'b1;
                    n_state         = S_SHORT_GO;
                end
            end
            S_SHORT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_short = 1'b1;
                n_state         = S_SHORT_WAIT;
            end
            S_SHORT_WAIT: begin
                o_cmd.div_short = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_write = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.last && i_status.mid) begin
                        n_state = S_SHORT_GO;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set output valid on emit, drop it after the transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output valid raised outside emit");

    a_flat_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) && i_status.flat |=> (r_state == S_IDLE) && !i_status.active)
        else $error("flat triangle left a walk active");

endmodule

`default_nettype wire

// File: design/triangle_edge_walker_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_first_x .. i_third_y
// output    out        o_out_valid / i_out_stall o_row_y, o_left_x, o_right_x, o_last_row
//
// A load sorts the vertices, forms the two area products and the area sign, and then,
// if not flat, divides the long and then the short edge in the shared restoring divider.
// A step emits one row; the step that reaches the middle vertex also divides
// the lower edge. A step on an idle walker emits no row.
// Reset (i_rst_n low, synchronous) leaves the walker idle with no result pending.
// A stalled result waits in the output register; the next item can still be
// taken, and a step waits for that register to drain.
module triangle_edge_walker_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_opcode,
    input  wire twalk_pkg::t_coord  i_first_x,
    input  wire twalk_pkg::t_coord  i_first_y,
    input  wire twalk_pkg::t_coord  i_second_x,
    input  wire twalk_pkg::t_coord  i_second_y,
    input  wire twalk_pkg::t_coord  i_third_x,
    input  wire twalk_pkg::t_coord  i_third_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output twalk_pkg::t_coord       o_row_y,
    output twalk_pkg::t_coord       o_left_x,
    output twalk_pkg::t_coord       o_right_x,
    output logic                    o_last_row
);

    twalk_pkg::t_dp_cmd    cmd;
    twalk_pkg::t_dp_status status;

    twalk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    twalk_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .o_row_y    (o_row_y),
        .o_left_x   (o_left_x),
        .o_right_x  (o_right_x),
        .o_last_row (o_last_row)
    );

endmodule

`default_nettype wire
